// ===== rtl/core/cffa_pkg.sv =====
// ----------------------------------------------------------------------------
// cffa_pkg: shared types and constants of the first-fit capacity allocator
// Beat payloads, operation codes, register map and parameter defaults.
// ----------------------------------------------------------------------------
package cffa_pkg;

   // Parameter defaults (SLOTS must be a power of two)
   localparam int SLOTS_DEFAULT         = 1024;
   localparam int CAPACITY_BITS_DEFAULT = 32;

   // Field widths fixed by the interface
   localparam int MODE_W      = 1;
   localparam int SLOT_W      = 10;
   localparam int AMOUNT_W    = 32;
   localparam int SLOTS_USE_W = 11;

   // Operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
   localparam logic [MODE_W-1:0] MODE_REQUEST = 1'b1;

   // Register map: register index is paddr[2]
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_SLOTS_IN_USE = 1'b0;
   localparam logic [SLOTS_USE_W-1:0] SLOTS_IN_USE_RESET = 11'd1024;

   // Request beat
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [SLOT_W-1:0]   slot;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   // Response beat
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] chosen_slot;
   } rsp_type;

endpackage

// ===== rtl/core/cffa_tree_mem.sv =====
// ----------------------------------------------------------------------------
// cffa_tree_mem: max tree storage
// One write port and two registered read ports over 2*SLOTS entries.
// ----------------------------------------------------------------------------
module cffa_tree_mem #(
   parameter int SLOTS         = 1024,
   parameter int CAPACITY_BITS = 32,
   parameter int NODE_W        = $clog2(2 * SLOTS)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [NODE_W-1:0]        wr_addr,
   input  logic [CAPACITY_BITS-1:0] wr_data,
   input  logic [NODE_W-1:0]        rd_addr_a,
   input  logic [NODE_W-1:0]        rd_addr_b,
   output logic [CAPACITY_BITS-1:0] rd_data_a,
   output logic [CAPACITY_BITS-1:0] rd_data_b
);

   logic [CAPACITY_BITS-1:0] mem [2 * SLOTS];
   logic [CAPACITY_BITS-1:0] rd_a_ff;
   logic [CAPACITY_BITS-1:0] rd_b_ff;

   // Write one node
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read two nodes, data registered
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/cffa_alu.sv =====
// ----------------------------------------------------------------------------
// cffa_alu: shared subtract and compare unit
// Gives a - b and whether a >= b from one subtractor.
// ----------------------------------------------------------------------------
module cffa_alu #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic             a_ge_b,
   output logic [WIDTH-1:0] diff
);

   logic [WIDTH:0] full_diff;

   // Subtract with borrow out; no borrow means a >= b
   assign full_diff = {1'b0, op_a} - {1'b0, op_b};
   assign a_ge_b    = ~full_diff[WIDTH];
   assign diff      = full_diff[WIDTH-1:0];

endmodule

// ===== rtl/core/cffa_csr.sv =====
// ----------------------------------------------------------------------------
// cffa_csr: configuration register file
// APB-style port holding the number of slots that take part in searches.
// ----------------------------------------------------------------------------
module cffa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cffa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cffa_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cffa_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [cffa_pkg::SLOTS_USE_W-1:0]   slots_in_use
);
   import cffa_pkg::*;

   logic [SLOTS_USE_W-1:0] slots_in_use_ff;
   logic [SLOTS_USE_W-1:0] slots_in_use_in;
   logic                   wr_beat;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite;

   // Take a write beat to the slot count register, drop other indexes
   always_comb begin
      slots_in_use_in = slots_in_use_ff;
      if (wr_beat && (paddr[2] == CSR_IDX_SLOTS_IN_USE)) begin
         slots_in_use_in = pwdata[SLOTS_USE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= SLOTS_IN_USE_RESET;
      end else begin
         slots_in_use_ff <= slots_in_use_in;
      end
   end

   // Read back
   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_SLOTS_IN_USE) begin
         prdata = CSR_DATA_W'(slots_in_use_ff);
      end
   end

   assign slots_in_use = slots_in_use_ff;

endmodule

// ===== rtl/core/cffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cffa_ctrl: allocation sequencer
// Clears the tree, walks it one level at a time and repairs the maxima,
// reusing one subtract and compare unit for every step.
// ----------------------------------------------------------------------------
module cffa_ctrl #(
   parameter int SLOTS         = 1024,
   parameter int CAPACITY_BITS = 32,
   parameter int NODE_W        = $clog2(2 * SLOTS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  cffa_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output cffa_pkg::rsp_type                rsp_data,
   input  logic [cffa_pkg::SLOTS_USE_W-1:0] slots_in_use,
   output logic                             mem_wr_en,
   output logic [NODE_W-1:0]                mem_wr_addr,
   output logic [CAPACITY_BITS-1:0]         mem_wr_data,
   output logic [NODE_W-1:0]                mem_rd_addr_a,
   output logic [NODE_W-1:0]                mem_rd_addr_b,
   input  logic [CAPACITY_BITS-1:0]         mem_rd_data_a,
   input  logic [CAPACITY_BITS-1:0]         mem_rd_data_b
);
   import cffa_pkg::*;

   localparam int ALU_W = (CAPACITY_BITS > AMOUNT_W) ? CAPACITY_BITS : AMOUNT_W;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_LOAD     = 4'd2;
   localparam logic [3:0] ST_ROOT_RD  = 4'd3;
   localparam logic [3:0] ST_ROOT_CMP = 4'd4;
   localparam logic [3:0] ST_DESC_RD  = 4'd5;
   localparam logic [3:0] ST_DESC_CMP = 4'd6;
   localparam logic [3:0] ST_LEAF     = 4'd7;
   localparam logic [3:0] ST_REP_RD   = 4'd8;
   localparam logic [3:0] ST_REP_WR   = 4'd9;

   localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);

   logic [3:0]               state_ff, state_in;
   logic [NODE_W-1:0]        node_ff, node_in;
   logic [CAPACITY_BITS-1:0] cur_ff, cur_in;
   logic [AMOUNT_W-1:0]      amount_ff, amount_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [ALU_W-1:0]         alu_a, alu_b, alu_diff;
   logic                     alu_ge;
   logic [NODE_W-1:0]        next_node;
   logic [NODE_W-2:0]        leaf_idx;
   logic                     accept;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign leaf_idx = node_ff[NODE_W-2:0];

   // Shared subtract and compare unit
   cffa_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .a_ge_b (alu_ge),
      .diff   (alu_diff)
   );

   // Select operands for the step in hand
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         ST_ROOT_CMP, ST_DESC_CMP: begin
            alu_a = ALU_W'(mem_rd_data_a);
            alu_b = ALU_W'(amount_ff);
         end
         ST_LEAF: begin
            alu_a = ALU_W'(cur_ff);
            alu_b = ALU_W'(amount_ff);
         end
         ST_REP_WR: begin
            alu_a = ALU_W'(cur_ff);
            alu_b = ALU_W'(mem_rd_data_a);
         end
         default: begin
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      amount_in     = amount_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = node_ff;
      mem_wr_data   = '0;
      mem_rd_addr_a = NODE_ROOT;
      mem_rd_addr_b = NODE_ROOT;
      next_node     = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep every node to zero
            mem_wr_en = 1'b1;
            node_in   = node_ff + NODE_W'(1);
            if (node_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               amount_in = req_data.amount;
               if (req_data.mode == MODE_LOAD) begin
                  if (32'(req_data.slot) < SLOTS) begin
                     node_in  = NODE_W'(SLOTS + 32'(req_data.slot));
                     cur_in   = CAPACITY_BITS'(req_data.amount);
                     state_in = ST_LOAD;
                  end
               end else begin
                  state_in = ST_ROOT_RD;
               end
            end
         end
         ST_LOAD: begin
            // Write the loaded leaf, then repair upwards
            mem_wr_en   = 1'b1;
            mem_wr_data = cur_ff;
            state_in    = ST_REP_RD;
         end
         ST_ROOT_RD: begin
            mem_rd_addr_a = NODE_ROOT;
            state_in      = ST_ROOT_CMP;
         end
         ST_ROOT_CMP: begin
            // Root holds the largest capacity: give up early if short
            if (alu_ge) begin
               node_in  = NODE_ROOT;
               state_in = ST_DESC_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_DESC_RD: begin
            mem_rd_addr_a = {node_ff[NODE_W-2:0], 1'b0};
            mem_rd_addr_b = {node_ff[NODE_W-2:0], 1'b1};
            state_in      = ST_DESC_CMP;
         end
         ST_DESC_CMP: begin
            // Prefer the left child; the right one fits otherwise
            if (alu_ge) begin
               next_node = {node_ff[NODE_W-2:0], 1'b0};
               cur_in    = mem_rd_data_a;
            end else begin
               next_node = {node_ff[NODE_W-2:0], 1'b1};
               cur_in    = mem_rd_data_b;
            end
            node_in  = next_node;
            state_in = next_node[NODE_W-1] ? ST_LEAF : ST_DESC_RD;
         end
         ST_LEAF: begin
            // Lowest fitting leaf; it counts only inside the slots in use
            if (32'(leaf_idx) < 32'(slots_in_use)) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = alu_diff[CAPACITY_BITS-1:0];
               cur_in      = alu_diff[CAPACITY_BITS-1:0];
               rsp_valid_in            = 1'b1;
               rsp_data_in.found       = 1'b1;
               rsp_data_in.chosen_slot = SLOT_W'(leaf_idx);
               state_in    = ST_REP_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_REP_RD: begin
            // Fetch the sibling, stop at the root
            mem_rd_addr_a = node_ff ^ NODE_W'(1);
            if (node_ff == NODE_ROOT) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_REP_WR;
            end
         end
         ST_REP_WR: begin
            // Parent takes the larger of the two children
            next_node   = node_ff >> 1;
            mem_wr_en   = 1'b1;
            mem_wr_addr = next_node;
            mem_wr_data = alu_ge ? cur_ff : mem_rd_data_a;
            cur_in      = mem_wr_data;
            node_in     = next_node;
            state_in    = ST_REP_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      amount_ff   <= amount_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // At most one response beat per item, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

   // A miss reports slot zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.chosen_slot == '0))
      else $error("miss with non-zero slot");

   // Descent never reaches a leaf without going through the compare step
   a_leaf_from_desc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEAF) |-> ($past(state_ff) == ST_DESC_CMP) && node_ff[NODE_W-1])
      else $error("leaf step entered out of order");

   // The clearing sweep ends in idle after the last node
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && node_ff == '1) |=> (state_ff == ST_IDLE))
      else $error("clearing sweep did not finish");

endmodule

// ===== rtl/core/first_fit_capacity_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_capacity_allocator_top: first-fit slot allocator over a max tree
// Keeps a remaining capacity per slot and hands out the lowest fitting slot.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the beat is taken at the
//   edge where start is high and busy is low. A load beat (mode 0) writes one
//   slot's capacity and gives no response. A request beat (mode 1) gives one
//   response beat on rsp_data, marked by rsp_valid for a single cycle.
//   Config port: APB-style, register 0 (byte address 0) is slots_in_use.
//   Walk: two tree steps per level over L = log2(SLOTS) levels. A request
//   answers at the leaf (at the root on an early miss) and after a hit stays busy
//   through the repair of the maxima; no new beat is taken before that is done.
//   A load writes its leaf and repairs the same way. The walk is paced by the
//   single tree memory and the one shared subtract and compare unit.
//   Reset: synchronous; afterwards a clearing sweep over every node zeroes
//   the tree with busy high. Config writes are taken throughout.
//   Stall: the receiver cannot stall; each response must be taken at once.
// ----------------------------------------------------------------------------
module first_fit_capacity_allocator_top #(
   parameter int SLOTS         = cffa_pkg::SLOTS_DEFAULT,
   parameter int CAPACITY_BITS = cffa_pkg::CAPACITY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  cffa_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output cffa_pkg::rsp_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cffa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cffa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cffa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import cffa_pkg::*;

   localparam int NODE_W = $clog2(2 * SLOTS);

   logic [SLOTS_USE_W-1:0]   slots_in_use;
   logic                     mem_wr_en;
   logic [NODE_W-1:0]        mem_wr_addr;
   logic [CAPACITY_BITS-1:0] mem_wr_data;
   logic [NODE_W-1:0]        mem_rd_addr_a;
   logic [NODE_W-1:0]        mem_rd_addr_b;
   logic [CAPACITY_BITS-1:0] mem_rd_data_a;
   logic [CAPACITY_BITS-1:0] mem_rd_data_b;

   // Configuration registers
   cffa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .slots_in_use (slots_in_use)
   );

   // Tree storage
   cffa_tree_mem #(
      .SLOTS         (SLOTS),
      .CAPACITY_BITS (CAPACITY_BITS),
      .NODE_W        (NODE_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   // Sequencer with the shared unit
   cffa_ctrl #(
      .SLOTS         (SLOTS),
      .CAPACITY_BITS (CAPACITY_BITS),
      .NODE_W        (NODE_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .slots_in_use  (slots_in_use),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr_a (mem_rd_addr_a),
      .mem_rd_addr_b (mem_rd_addr_b),
      .mem_rd_data_a (mem_rd_data_a),
      .mem_rd_data_b (mem_rd_data_b)
   );

endmodule

// ===== bench/first_fit_capacity_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// first_fit_capacity_allocator_checker: grant predictor and response checker
// Watches the request, response and register ports of the allocator. Keeps
// its own copy of every slot's remaining capacity and of slots_in_use. Works
// out the grant of each request beat and compares it field by field with the
// response beats as they arrive.
// ----------------------------------------------------------------------------
module first_fit_capacity_allocator_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  cffa_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  cffa_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cffa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cffa_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [cffa_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              awaiting,
   output int                              mismatches
);
   import cffa_pkg::*;

   logic [AMOUNT_W-1:0]    slot_room [0:SLOTS_DEFAULT-1];
   logic [SLOTS_USE_W-1:0] live_slots;
   rsp_type                grant_queue [$];
   int                     error_tally = 0;
   int                     n;
   rsp_type                due;

   // Find the lowest slot in use that holds enough and take the amount from it
   function automatic rsp_type first_fit_grant(input logic [AMOUNT_W-1:0] need);
      rsp_type grant;
      int      reach;
      int      i;
      grant = '0;
      reach = (live_slots > SLOTS_DEFAULT) ? SLOTS_DEFAULT : int'(live_slots);
      for (i = 0; i < reach; i++) begin
         if (slot_room[i] >= need) begin
            slot_room[i]      = slot_room[i] - need;
            grant.found       = 1'b1;
            grant.chosen_slot = SLOT_W'(i);
            break;
         end
      end
      return grant;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (n = 0; n < SLOTS_DEFAULT; n++) slot_room[n] = '0;
         live_slots = SLOTS_IN_USE_RESET;
         grant_queue.delete();
      end else begin
         // compare a response beat with the oldest grant
         if (rsp_valid !== 1'b0) begin
            if (grant_queue.size() == 0) begin
               $error("response beat with no grant outstanding: found %0d slot %0d",
                      rsp_data.found, rsp_data.chosen_slot);
               error_tally++;
            end else begin
               due = grant_queue.pop_front();
               if (rsp_data.found !== due.found) begin
                  $error("found: expected %0d, actual %0d", due.found, rsp_data.found);
                  error_tally++;
               end
               if (rsp_data.chosen_slot !== due.chosen_slot) begin
                  $error("chosen_slot: expected %0d, actual %0d",
                         due.chosen_slot, rsp_data.chosen_slot);
                  error_tally++;
               end
            end
         end

         // track register writes, check reads of slots_in_use
         if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
            if (pwrite) begin
               if (paddr[2] == CSR_IDX_SLOTS_IN_USE) live_slots = pwdata[SLOTS_USE_W-1:0];
            end else if (paddr[2] == CSR_IDX_SLOTS_IN_USE &&
                         prdata !== CSR_DATA_W'(live_slots)) begin
               $error("slots_in_use: expected %0d, actual %0d", live_slots, prdata);
               error_tally++;
            end
         end

         // apply an accepted request beat
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_data.mode == MODE_LOAD) slot_room[req_data.slot] = req_data.amount;
            else grant_queue.insert(grant_queue.size(), first_fit_grant(req_data.amount));
         end
      end
      awaiting   <= grant_queue.size();
      mismatches <= error_tally;
   end

endmodule

// ===== bench/first_fit_capacity_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_capacity_allocator_top_tb: stimulus and verdict for the allocator
// Drives load and request beats and register accesses: a directed opening on
// the corner cases, then random phases over several slots_in_use settings,
// with random gaps on the request side but in one phase. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module first_fit_capacity_allocator_top_tb;
   import cffa_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    awaiting;
   int                    mismatches;
   int                    quiet_cycles = 0;
   bit                    no_gaps = 1'b0;

   always #6 clock = ~clock;

   first_fit_capacity_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   first_fit_capacity_allocator_checker grant_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .awaiting   (awaiting),
      .mismatches (mismatches)
   );

   // Drop the run after too long without any beat taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("first_fit_capacity_allocator_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one beat, idling first at random; start stays high after the beat
   task automatic send_beat(input req_type beat);
      while (!no_gaps && $urandom_range(0, 99) < 14) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [AMOUNT_W-1:0] amount);
      req_type beat;
      beat.mode   = MODE_LOAD;
      beat.slot   = slot;
      beat.amount = amount;
      send_beat(beat);
   endtask

   task automatic ask(input logic [AMOUNT_W-1:0] amount);
      req_type beat;
      beat.mode   = MODE_REQUEST;
      beat.slot   = SLOT_W'($urandom);
      beat.amount = amount;
      send_beat(beat);
   endtask

   // Hold off new beats until every grant has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Let the block go idle, then write slots_in_use (junk above its width) and read it
   task automatic set_slots(input logic [SLOTS_USE_W-1:0] setting);
      logic [CSR_DATA_W-1:0] word;
      drain();
      repeat (60) @(posedge clock);
      word = $urandom;
      word[SLOTS_USE_W-1:0] = setting;
      csr_access(1'b1, 3'd0, word);
      csr_access(1'b0, 3'd0, '0);
   endtask

   // Mostly small capacities and requests so that grants keep landing
   task automatic random_phase(input logic [SLOTS_USE_W-1:0] setting, input int beats);
      int      reach;
      int      k;
      int      roll;
      req_type beat;
      reach = (setting > SLOTS_DEFAULT) ? SLOTS_DEFAULT : int'(setting);
      set_slots(setting);
      for (k = 0; k < beats; k++) begin
         beat.slot = SLOT_W'($urandom);
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 45) begin
            beat.mode = MODE_LOAD;
            if (reach > 0 && $urandom_range(0, 4) != 0)
               beat.slot = SLOT_W'($urandom_range(0, reach - 1));
            if (roll < 60) beat.amount = $urandom_range(0, 1000);
            else if (roll < 85) beat.amount = $urandom;
            else beat.amount = roll[0] ? '1 : '0;
         end else begin
            beat.mode = MODE_REQUEST;
            if (roll < 60) beat.amount = $urandom_range(0, 400);
            else if (roll < 80) beat.amount = $urandom;
            else if (roll < 90) beat.amount = '0;
            else beat.amount = '1;
         end
         send_beat(beat);
         if ($urandom_range(0, 99) == 0) drain();
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full store in use; an unknown register write must change nothing
      csr_access(1'b1, 3'd0, CSR_DATA_W'(SLOTS_IN_USE_RESET));
      csr_access(1'b1, 3'd4, $urandom);
      csr_access(1'b0, 3'd0, '0);

      // zero request on an empty store, then extremes of slot and amount
      ask('0);
      ask(32'd1);
      load_slot(10'd0, 32'hFFFF_FFFF);
      load_slot(10'd1023, 32'd5);
      load_slot(10'd512, 32'd100);
      load_slot(10'd341, 32'h5555_5555);
      load_slot(10'd682, 32'hAAAA_AAAA);
      ask(32'hFFFF_FFFF);
      ask(32'h6000_0000);
      ask(32'd6);
      ask('0);
      ask(32'h8000_0000);
      load_slot(10'd1023, 32'h8000_0000);
      ask(32'h8000_0000);

      // no slots in use: nothing fits, loads still land
      set_slots('0);
      ask('0);
      ask(32'd1);
      load_slot(10'd3, 32'd7);

      // the slot loaded while out of use joins the search again
      set_slots(11'd4);
      ask(32'd7);
      ask('0);

      // a setting above the store size acts as the full store
      set_slots(11'd2047);
      load_slot(10'd1023, 32'd9);
      ask(32'd9);
      ask(32'd5);

      random_phase(11'd1, 140);
      random_phase(11'd2, 140);
      random_phase(11'd16, 140);
      no_gaps = 1'b1;
      random_phase(11'd1024, 150);
      no_gaps = 1'b0;
      random_phase(SLOTS_USE_W'($urandom_range(3, 1023)), 140);
      random_phase(11'd2047, 140);
      random_phase(11'd0, 60);
      random_phase(11'd1000, 140);
      random_phase(11'd37, 140);
      random_phase(11'd1024, 140);

      drain();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("first_fit_capacity_allocator_top_tb OK");
      end else begin
         $display("first_fit_capacity_allocator_top_tb NOT OK");
      end
      $finish;
   end

endmodule
